[design/sswas_pkg.sv]
// ----------------------------------------------------------------------------
// sswas_pkg
// Shared widths and result codes for the series statistics block.
// ----------------------------------------------------------------------------
package sswas_pkg;

    // field and accumulator widths
    localparam int SAMPLE_W = 32;
    localparam int SUM_W    = 37;
    localparam int POS_W    = 5;
    localparam int KIND_W   = 3;

    // result kinds
    localparam logic [KIND_W-1:0] KIND_MIN  = 3'd0;
    localparam logic [KIND_W-1:0] KIND_MAX  = 3'd1;
    localparam logic [KIND_W-1:0] KIND_MEAN = 3'd2;
    localparam logic [KIND_W-1:0] KIND_WIN  = 3'd3;
    localparam logic [KIND_W-1:0] KIND_SORT = 3'd4;

    typedef logic [SAMPLE_W-1:0] t_sample;
    typedef logic [SUM_W-1:0]    t_sum;
    typedef logic [POS_W-1:0]    t_pos;

endpackage

[design/sswas_ram.sv]
// ----------------------------------------------------------------------------
// sswas_ram
// Generic single-write, single-read RAM with a registered read port.
// ----------------------------------------------------------------------------
module sswas_ram #(
    parameter int WIDTH = 32,
    parameter int DEPTH = 12,
    parameter int AW    = 4
) (
    input  logic             i_clk,
    input  logic             i_we,
    input  logic [AW-1:0]    i_waddr,
    input  logic [WIDTH-1:0] i_wdata,
    input  logic [AW-1:0]    i_raddr,
    output logic [WIDTH-1:0] o_rdata
);

    logic [WIDTH-1:0] r_mem [DEPTH];
    logic [WIDTH-1:0] r_rdata;

    // write port and registered read port
    always_ff @(posedge i_clk) begin
        if (i_we) begin
            r_mem[i_waddr] <= i_wdata;
        end
        r_rdata <= r_mem[i_raddr];
    end

    assign o_rdata = r_rdata;

endmodule

[design/sswas_div.sv]
// ----------------------------------------------------------------------------
// sswas_div
// Division by a constant through reciprocal multiplication for the rounded
// averages: four partial products accumulated in turn.
// ----------------------------------------------------------------------------
module sswas_div #(
    parameter int NUM_W = 39,
    parameter int REC_W = 44,
    parameter int SHIFT = 44
) (
    input  logic                          i_clk,
    input  logic                          i_rst_n,
    input  logic                          i_start,
    input  logic [NUM_W-1:0]              i_num,
    input  logic [REC_W-1:0]              i_recip,
    output logic                          o_done,
    output logic [sswas_pkg::SAMPLE_W-1:0] o_quot
);
    import sswas_pkg::*;

    localparam int NLO_W  = (NUM_W + 1) / 2;
    localparam int RLO_W  = (REC_W + 1) / 2;
    localparam int PP_W   = NLO_W + RLO_W;
    localparam int PROD_W = NUM_W + REC_W;

    logic [NUM_W-1:0]  r_num;
    logic [REC_W-1:0]  r_rec;
    logic [PROD_W-1:0] r_acc;
    logic [1:0]        r_step;
    logic              r_busy;
    logic              r_done;

    logic [NLO_W-1:0]  w_a;
    logic [RLO_W-1:0]  w_b;
    logic [PP_W-1:0]   w_pp;
    logic [PROD_W-1:0] w_term;

    // pick the halves for this step: bit 1 selects the upper dividend half,
    // bit 0 the upper reciprocal half
    always_comb begin
        w_a = r_step[1] ? NLO_W'(r_num[NUM_W-1:NLO_W]) : r_num[NLO_W-1:0];
        w_b = r_step[0] ? RLO_W'(r_rec[REC_W-1:RLO_W]) : r_rec[RLO_W-1:0];
    end

    // partial product, aligned to its weight
    assign w_pp = PP_W'(w_a) * PP_W'(w_b);

    always_comb begin
        w_term = PROD_W'(w_pp);
        case (r_step)
            2'd1: begin
                w_term = PROD_W'(w_pp) << RLO_W;
            end
            2'd2: begin
                w_term = PROD_W'(w_pp) << NLO_W;
            end
            2'd3: begin
                w_term = PROD_W'(w_pp) << (NLO_W + RLO_W);
            end
            default: begin
            end
        endcase
    end

    // step counter and completion flag
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_busy <= 1'b0;
            r_done <= 1'b0;
            r_step <= '0;
        end else if (i_start) begin
            r_busy <= 1'b1;
            r_done <= 1'b0;
            r_step <= '0;
        end else if (r_busy) begin
            r_step <= r_step + 1'b1;
            if (r_step == 2'd3) begin
                r_busy <= 1'b0;
                r_done <= 1'b1;
            end
        end
    end

    // capture operands, accumulate the product
    always_ff @(posedge i_clk) begin
        if (i_start) begin
            r_num <= i_num;
            r_rec <= i_recip;
            r_acc <= '0;
        end else if (r_busy) begin
            r_acc <= r_acc + w_term;
        end
    end

    assign o_done = r_done;
    assign o_quot = r_acc[SHIFT +: SAMPLE_W];

endmodule

[design/series_stats_window_avg_sort.sv]
// ----------------------------------------------------------------------------
// series_stats_window_avg_sort
// Min, max, mean, moving averages and a descending sort over a set of values.
// ----------------------------------------------------------------------------
// Each accepted item is written to the sample RAM at its arrival index,
// inserted into a descending chain of value/index cells, and folded into
// the running minimum, maximum and total. The item that completes a set of
// ITEMS values starts the result phase, during which the input is stalled.
// Results come out as minimum, maximum, mean, one moving average per window
// start (when WINDOW <= ITEMS) and then all values from highest to lowest
// with their arrival index, ties in arrival order; last_of_run marks the
// final sorted entry. Averages are rounded half up; each divides by a
// constant through a reciprocal multiplication built from four partial
// products. The first window sum is built from WINDOW reads of the sample
// RAM (each read passes through S_W_RD and S_W_UPD) and each further one
// from two reads (remove the oldest, add the newest), over a total of
// NW = ITEMS - WINDOW + 1 windows. The next set is accepted while the last
// result still waits in the output register.
// ----------------------------------------------------------------------------
module series_stats_window_avg_sort #(
    parameter int ITEMS  = 12,
    parameter int WINDOW = 6
) (
    input  logic                          i_clk,
    input  logic                          i_rst_n,
    input  logic                          i_valid,
    output logic                          o_stall,
    input  logic [sswas_pkg::SAMPLE_W-1:0] i_sample_cents,
    output logic                          o_valid,
    input  logic                          i_stall,
    output logic [sswas_pkg::KIND_W-1:0]   o_result_kind,
    output logic [sswas_pkg::SAMPLE_W-1:0] o_value_cents,
    output logic [sswas_pkg::POS_W-1:0]    o_position,
    output logic                          o_last_of_run
);
    import sswas_pkg::*;

    localparam int AW      = (ITEMS > 1) ? $clog2(ITEMS) : 1;
    localparam int NUM_W   = SUM_W + 2;
    localparam int MAXN    = (ITEMS > WINDOW) ? ITEMS : WINDOW;
    localparam int SHIFT   = NUM_W + $clog2(2 * MAXN);
    localparam int REC_W   = SHIFT;
    localparam bit HAS_WIN = (WINDOW <= ITEMS);

    // reciprocals of the divisors 2*ITEMS and 2*WINDOW, rounded up
    localparam logic [REC_W-1:0] REC_MEAN =
        REC_W'(((64'd1 << SHIFT) + 64'(2 * ITEMS - 1)) / 64'(2 * ITEMS));
    localparam logic [REC_W-1:0] REC_WIN  =
        REC_W'(((64'd1 << SHIFT) + 64'(2 * WINDOW - 1)) / 64'(2 * WINDOW));

    localparam t_pos LAST_POS = POS_W'(ITEMS - 1);
    localparam t_pos LAST_WIN = POS_W'(HAS_WIN ? (ITEMS - WINDOW) : 0);
    localparam t_pos WIN_END  = POS_W'(WINDOW - 1);

    // controller states
    localparam logic [3:0] S_LOAD     = 4'd0;
    localparam logic [3:0] S_MIN      = 4'd1;
    localparam logic [3:0] S_MAX      = 4'd2;
    localparam logic [3:0] S_DIV_GO   = 4'd3;
    localparam logic [3:0] S_DIV_WAIT = 4'd4;
    localparam logic [3:0] S_EMIT_DIV = 4'd5;
    localparam logic [3:0] S_W_RD     = 4'd6;
    localparam logic [3:0] S_W_UPD    = 4'd7;
    localparam logic [3:0] S_SORT     = 4'd8;

    logic [3:0] r_state;
    logic [3:0] n_state;

    // running statistics
    t_pos    r_count;
    t_sample r_min;
    t_sample r_max;
    t_sum    r_total;

    // sorting chain
    t_sample    r_key [ITEMS];
    t_pos       r_idx [ITEMS];
    logic [ITEMS-1:0] w_ge;

    // window walk
    t_sum r_wsum;
    t_pos r_addr;
    t_pos r_win;
    t_pos r_pos;
    logic r_fill;
    logic r_sub;
    logic r_div_mean;

    // output register
    logic            r_out_valid;
    logic [KIND_W-1:0] r_kind;
    t_sample         r_val;
    t_pos            r_opos;
    logic            r_last;

    logic [KIND_W-1:0] w_kind;
    t_sample         w_val;
    t_pos            w_opos;
    logic            w_last;

    logic w_in_acc;
    logic w_slot;
    logic w_emit;
    logic w_sort_end;

    t_sample          w_rdata;
    t_sum             w_rd_ext;
    logic [NUM_W-1:0] w_num;
    logic [REC_W-1:0] w_recip;
    logic             w_div_done;
    t_sample          w_quot;

    assign o_stall    = (r_state != S_LOAD);
    assign w_in_acc   = i_valid && (r_state == S_LOAD);
    assign w_slot     = !r_out_valid || !i_stall;
    assign w_emit     = w_slot && ((r_state == S_MIN) || (r_state == S_MAX) ||
                                   (r_state == S_EMIT_DIV) || (r_state == S_SORT));
    assign w_sort_end = w_slot && (r_state == S_SORT) && (r_pos == LAST_POS);
    assign w_rd_ext   = SUM_W'(w_rdata);

    // sample store
    sswas_ram #(
        .WIDTH (SAMPLE_W),
        .DEPTH (ITEMS),
        .AW    (AW)
    ) u_sample_ram (
        .i_clk   (i_clk),
        .i_we    (w_in_acc),
        .i_waddr (r_count[AW-1:0]),
        .i_wdata (i_sample_cents),
        .i_raddr (r_addr[AW-1:0]),
        .o_rdata (w_rdata)
    );

    // rounded average: (2*sum + n) / (2*n)
    assign w_num   = r_div_mean ? ({1'b0, r_total, 1'b0} + NUM_W'(ITEMS))
                                : ({1'b0, r_wsum, 1'b0} + NUM_W'(WINDOW));
    assign w_recip = r_div_mean ? REC_MEAN : REC_WIN;

    sswas_div #(
        .NUM_W (NUM_W),
        .REC_W (REC_W),
        .SHIFT (SHIFT)
    ) u_div (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_start (r_state == S_DIV_GO),
        .i_num   (w_num),
        .i_recip (w_recip),
        .o_done  (w_div_done),
        .o_quot  (w_quot)
    );

    // find cells that stay ahead of the new item (equal values keep priority)
    always_comb begin
        for (int i = 0; i < ITEMS; i++) begin
            w_ge[i] = (POS_W'(i) < r_count) && (r_key[i] >= i_sample_cents);
        end
    end

    // insert the new item, shift the cells behind it down by one
    for (genvar g = 0; g < ITEMS; g++) begin : g_chain
        always_ff @(posedge i_clk) begin
            if (w_in_acc && !w_ge[g]) begin
                if (g == 0) begin
                    r_key[g] <= i_sample_cents;
                    r_idx[g] <= r_count;
                end else if (w_ge[(g > 0) ? g - 1 : 0]) begin
                    r_key[g] <= i_sample_cents;
                    r_idx[g] <= r_count;
                end else begin
                    r_key[g] <= r_key[(g > 0) ? g - 1 : 0];
                    r_idx[g] <= r_idx[(g > 0) ? g - 1 : 0];
                end
            end
        end
    end

    // sequence the result phase
    always_comb begin
        n_state = r_state;
        unique case (r_state)
            S_LOAD: begin
                if (w_in_acc && (r_count == LAST_POS)) n_state = S_MIN;
            end
            S_MIN: begin
                if (w_slot) n_state = S_MAX;
            end
            S_MAX: begin
                if (w_slot) n_state = S_DIV_GO;
            end
            S_DIV_GO: begin
                n_state = S_DIV_WAIT;
            end
            S_DIV_WAIT: begin
                if (w_div_done) n_state = S_EMIT_DIV;
            end
            S_EMIT_DIV: begin
                if (w_slot) begin
                    if (r_div_mean) begin
                        n_state = HAS_WIN ? S_W_RD : S_SORT;
                    end else begin
                        n_state = (r_win == LAST_WIN) ? S_SORT : S_W_RD;
                    end
                end
            end
            S_W_RD: begin
                n_state = S_W_UPD;
            end
            S_W_UPD: begin
                if (r_fill) begin
                    n_state = (r_addr == WIN_END) ? S_DIV_GO : S_W_RD;
                end else if (r_sub) begin
                    n_state = S_W_RD;
                end else begin
                    n_state = S_DIV_GO;
                end
            end
            S_SORT: begin
                if (w_sort_end) n_state = S_LOAD;
            end
            default: begin
                n_state = S_LOAD;
            end
        endcase
    end

    // control state, running statistics and output valid
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state     <= S_LOAD;
            r_count     <= '0;
            r_min       <= '1;
            r_max       <= '0;
            r_total     <= '0;
            r_out_valid <= 1'b0;
        end else begin
            r_state <= n_state;
            if (w_emit) begin
                r_out_valid <= 1'b1;
            end else if (!i_stall) begin
                r_out_valid <= 1'b0;
            end
            if (w_in_acc) begin
                r_count <= r_count + 1'b1;
                r_total <= r_total + SUM_W'(i_sample_cents);
                if (i_sample_cents < r_min) r_min <= i_sample_cents;
                if (i_sample_cents > r_max) r_max <= i_sample_cents;
            end else if (w_sort_end) begin
                r_count <= '0;
                r_min   <= '1;
                r_max   <= '0;
                r_total <= '0;
            end
        end
    end

    // walk the windows and the sorted chain
    always_ff @(posedge i_clk) begin
        case (r_state)
            S_MAX: begin
                if (w_slot) begin
                    r_div_mean <= 1'b1;
                    r_pos      <= '0;
                end
            end
            S_EMIT_DIV: begin
                if (w_slot) begin
                    r_div_mean <= 1'b0;
                    if (r_div_mean) begin
                        r_wsum <= '0;
                        r_addr <= '0;
                        r_win  <= '0;
                        r_fill <= 1'b1;
                        r_sub  <= 1'b0;
                    end else begin
                        r_sub  <= 1'b1;
                        r_addr <= r_win;
                        r_win  <= r_win + 1'b1;
                    end
                end
            end
            S_W_UPD: begin
                if (r_fill) begin
                    r_wsum <= r_wsum + w_rd_ext;
                    if (r_addr == WIN_END) begin
                        r_fill <= 1'b0;
                    end else begin
                        r_addr <= r_addr + 1'b1;
                    end
                end else if (r_sub) begin
                    r_wsum <= r_wsum - w_rd_ext;
                    r_sub  <= 1'b0;
                    r_addr <= r_win + WIN_END;
                end else begin
                    r_wsum <= r_wsum + w_rd_ext;
                end
            end
            S_SORT: begin
                if (w_slot) r_pos <= r_pos + 1'b1;
            end
            default: begin
            end
        endcase
    end

    // select the result for the output register
    always_comb begin
        w_kind = KIND_SORT;
        w_val  = r_key[r_pos[AW-1:0]];
        w_opos = r_idx[r_pos[AW-1:0]];
        w_last = (r_pos == LAST_POS);
        case (r_state)
            S_MIN: begin
                w_kind = KIND_MIN;
                w_val  = r_min;
                w_opos = '0;
                w_last = 1'b0;
            end
            S_MAX: begin
                w_kind = KIND_MAX;
                w_val  = r_max;
                w_opos = '0;
                w_last = 1'b0;
            end
            S_EMIT_DIV: begin
                w_kind = r_div_mean ? KIND_MEAN : KIND_WIN;
                w_val  = w_quot;
                w_opos = r_div_mean ? '0 : r_win;
                w_last = 1'b0;
            end
            default: begin
            end
        endcase
    end

    // hold the result until taken
    always_ff @(posedge i_clk) begin
        if (w_emit) begin
            r_kind <= w_kind;
            r_val  <= w_val;
            r_opos <= w_opos;
            r_last <= w_last;
        end
    end

    assign o_valid       = r_out_valid;
    assign o_result_kind = r_kind;
    assign o_value_cents = r_val;
    assign o_position    = r_opos;
    assign o_last_of_run = r_last;

endmodule
